// File: rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the signed decimal field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  // Field limits
  localparam int RESULT_LIMIT  = 64;
  localparam int MAX_FIELD_DEF = 64;
  localparam int NUM_DIGITS    = 20;   // enough for 2^63 in decimal

  // Conversion steps, two magnitude bits per step
  localparam int LONG_STEPS  = 32;
  localparam int SHORT_STEPS = 16;

  // ASCII codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_PLUS  = 7'h2B;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FIELD_WIDTH     = 3'd0,
    CFG_PRECISION       = 3'd1,
    CFG_PRECISION_GIVEN = 3'd2,
    CFG_PLUS_FLAG       = 3'd3,
    CFG_SPACE_FLAG      = 3'd4,
    CFG_LEFT_JUSTIFY    = 3'd5,
    CFG_VALUE_IS_LONG   = 3'd6
  } cfg_index_t;

  // Configuration register file
  typedef struct packed {
    logic [6:0] field_width;
    logic [5:0] precision;
    logic       precision_given;
    logic       plus_flag;
    logic       space_flag;
    logic       left_justify;
    logic       value_is_long;
  } cfg_t;

  // Start request from the top level to the emitter
  typedef struct packed {
    logic start;
    logic negative;
  } emit_req_t;

  // Top level sequencer
  typedef enum logic [1:0] {
    T_IDLE,
    T_CONV,
    T_EMIT
  } top_state_t;

  // Emitter sequencer
  typedef enum logic [2:0] {
    E_IDLE,
    E_MEAS,
    E_SETUP,
    E_PICK,
    E_RUN
  } emit_state_t;

  // Output segments, in field order
  typedef enum logic [2:0] {
    SEG_PADL  = 3'd0,
    SEG_SIGN  = 3'd1,
    SEG_ZERO  = 3'd2,
    SEG_DIGIT = 3'd3,
    SEG_PADR  = 3'd4
  } seg_t;

  localparam int NUM_SEGS = 5;

endpackage

`default_nettype wire

// File: rtl/sdf_bcd_unit.sv
// ----------------------------------------------------------------------------
// sdf_bcd_unit
// Iterative binary to BCD converter (shift and add-3), two bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_bcd_unit (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      start,
  input  wire logic [63:0]                               mag,
  input  wire logic [4:0]                                last_step,
  output logic                                           busy,
  output logic [sdf_pkg::NUM_DIGITS-1:0][3:0]            digits
);

  // One shift-and-add-3 pass: adjust every digit, then shift in one bit.
  // The top bit of the top digit is always zero for a 64-bit magnitude.
  function automatic logic [sdf_pkg::NUM_DIGITS-1:0][3:0] dabble(
    input logic [sdf_pkg::NUM_DIGITS-1:0][3:0] bcd_in,
    input logic                                bit_in
  );
    logic [sdf_pkg::NUM_DIGITS-1:0][3:0] adj;
    logic [4*sdf_pkg::NUM_DIGITS-1:0]    flat;
    for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
      adj[i] = (bcd_in[i] >= 4'd5) ? bcd_in[i] + 4'd3 : bcd_in[i];
    end
    flat = adj;
    return {flat[4*sdf_pkg::NUM_DIGITS-2:0], bit_in};
  endfunction

  logic [63:0] shreg;
  logic [4:0]  cnt;
  logic [sdf_pkg::NUM_DIGITS-1:0][3:0] bcd_step1;

  // Two dependent passes per cycle
  assign bcd_step1 = dabble(digits, shreg[63]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= last_step;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg  <= mag;
      digits <= '0;
    end else if (busy) begin
      shreg  <= {shreg[61:0], 2'b00};
      digits <= dabble(bcd_step1, shreg[62]);
    end
  end

endmodule

`default_nettype wire

// File: rtl/sdf_emit.sv
// ----------------------------------------------------------------------------
// sdf_emit
// Field sequencer: measures the digit count, sizes the pad, sign, zero and
// digit segments, and emits one character per transfer through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_emit #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire sdf_pkg::cfg_t                        cfg,
  input  wire sdf_pkg::emit_req_t                   req,
  input  wire logic [sdf_pkg::NUM_DIGITS-1:0][3:0]  digits,
  output logic                                      busy,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [6:0]                                character,
  output logic                                      is_last
);

  localparam int CAP_INT = (MAX_FIELD < sdf_pkg::RESULT_LIMIT) ? MAX_FIELD
                                                               : sdf_pkg::RESULT_LIMIT;
  localparam logic [6:0] WIDTH_CAP = 7'(CAP_INT);

  sdf_pkg::emit_state_t state, state_next;
  sdf_pkg::seg_t        seg, seg_next;
  logic [6:0] cnt, cnt_next;
  logic [6:0] rem, rem_next;
  logic [4:0] ndig, ndig_next;
  logic [6:0] pad, pad_next;
  logic [5:0] nzero, nzero_next;
  logic       has_sign, has_sign_next;
  logic [6:0] sign_ch, sign_ch_next;
  logic       negative;

  logic       emit_fire;
  logic [6:0] seg_len [sdf_pkg::NUM_SEGS];
  logic [2:0] search_base;
  logic       found;
  logic [2:0] found_seg;
  logic [6:0] found_len;
  logic [4:0] dig_idx;
  logic [6:0] cur_char;

  // Setup arithmetic
  logic [6:0] prec_req, prec, content, width, total;

  assign busy      = (state != sdf_pkg::E_IDLE);
  assign emit_fire = (state == sdf_pkg::E_RUN) && (!out_valid || out_ready);

  // Segment lengths in field order
  always_comb begin
    seg_len[0] = cfg.left_justify ? 7'd0 : pad;
    seg_len[1] = {6'd0, has_sign};
    seg_len[2] = {1'b0, nzero};
    seg_len[3] = {2'd0, ndig};
    seg_len[4] = cfg.left_justify ? pad : 7'd0;
  end

  // First non-empty segment at or after the search base
  always_comb begin
    search_base = (state == sdf_pkg::E_PICK) ? 3'd0 : (3'(seg) + 3'd1);
    found       = 1'b0;
    found_seg   = 3'd0;
    found_len   = 7'd0;
    for (int o = 0; o < sdf_pkg::NUM_SEGS; o++) begin
      if (!found && (3'(o) >= search_base) && (seg_len[o] != 7'd0)) begin
        found     = 1'b1;
        found_seg = 3'(o);
        found_len = seg_len[o];
      end
    end
  end

  // Field sizing
  always_comb begin
    prec_req = cfg.precision_given ? {1'b0, cfg.precision} : 7'd1;
    prec     = (prec_req < {2'd0, ndig}) ? {2'd0, ndig} : prec_req;
    content  = prec + {6'd0, has_sign};
    width    = (cfg.field_width > WIDTH_CAP) ? WIDTH_CAP : cfg.field_width;
    total    = (content > width) ? content : width;
  end

  // Character of the current segment
  assign dig_idx = 5'(cnt - 7'd1);
  always_comb begin
    unique case (seg)
      sdf_pkg::SEG_PADL:  cur_char = sdf_pkg::CH_SPACE;
      sdf_pkg::SEG_SIGN:  cur_char = sign_ch;
      sdf_pkg::SEG_ZERO:  cur_char = sdf_pkg::CH_ZERO;
      sdf_pkg::SEG_DIGIT: cur_char = sdf_pkg::CH_ZERO | {3'd0, digits[dig_idx]};
      sdf_pkg::SEG_PADR:  cur_char = sdf_pkg::CH_SPACE;
      default:            cur_char = sdf_pkg::CH_SPACE;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdf_pkg::E_IDLE:  if (req.start) state_next = sdf_pkg::E_MEAS;
      sdf_pkg::E_MEAS:  state_next = sdf_pkg::E_SETUP;
      sdf_pkg::E_SETUP: state_next = sdf_pkg::E_PICK;
      sdf_pkg::E_PICK:  state_next = found ? sdf_pkg::E_RUN : sdf_pkg::E_IDLE;
      sdf_pkg::E_RUN:   if (emit_fire && rem == 7'd1) state_next = sdf_pkg::E_IDLE;
      default:          state_next = sdf_pkg::E_IDLE;
    endcase
  end

  // Datapath next values
  always_comb begin
    seg_next      = seg;
    cnt_next      = cnt;
    rem_next      = rem;
    ndig_next     = ndig;
    pad_next      = pad;
    nzero_next    = nzero;
    has_sign_next = has_sign;
    sign_ch_next  = sign_ch;
    unique case (state)
      sdf_pkg::E_IDLE: begin
        // sign is known at start
        has_sign_next = req.negative | cfg.plus_flag | cfg.space_flag;
        sign_ch_next  = req.negative ? sdf_pkg::CH_MINUS :
                        cfg.plus_flag ? sdf_pkg::CH_PLUS : sdf_pkg::CH_SPACE;
      end
      sdf_pkg::E_MEAS: begin
        // digit count: highest nonzero digit
        ndig_next = 5'd0;
        for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
          if (digits[i] != 4'd0) ndig_next = 5'(i + 1);
        end
      end
      sdf_pkg::E_SETUP: begin
        pad_next   = total - content;
        nzero_next = 6'(prec - {2'd0, ndig});
        rem_next   = total;
      end
      sdf_pkg::E_PICK: begin
        seg_next = sdf_pkg::seg_t'(found_seg);
        cnt_next = found_len;
      end
      sdf_pkg::E_RUN: begin
        if (emit_fire) begin
          rem_next = rem - 7'd1;
          if (cnt == 7'd1) begin
            seg_next = sdf_pkg::seg_t'(found_seg);
            cnt_next = found_len;
          end else begin
            cnt_next = cnt - 7'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign negative = req.negative;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdf_pkg::E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    seg      <= seg_next;
    cnt      <= cnt_next;
    rem      <= rem_next;
    ndig     <= ndig_next;
    pad      <= pad_next;
    nzero    <= nzero_next;
    has_sign <= has_sign_next;
    sign_ch  <= (state == sdf_pkg::E_IDLE && negative) ? sdf_pkg::CH_MINUS : sign_ch_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      character <= cur_char;
      is_last   <= (rem == 7'd1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/signed_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// Formats one signed integer as printf %d text, one ASCII character per
// output transfer, the last one flagged.
//
//   channel  signals                                  role
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  register write
//   in       in_valid/in_ready, value                  value to format
//   out      out_valid/out_ready, character, is_last   field characters
//
// Between one input transfer and the next, an item passes through S steps of
// the shift/add-3 BCD unit (S is 16 for a 32-bit value, 32 for a 64-bit
// value), the emitter start, the states that measure, size and pick the
// first segment, N field characters at one character per cycle from the
// output register unless out_ready stalls it, and the return to idle.
// The block takes one item at a time; in_ready is high only when idle.
// The last character may still wait in the output register when the next
// item is taken. Reset zeroes cfg and idles the sequencers; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_decimal_field_formatter #(
  parameter int MAX_FIELD = sdf_pkg::MAX_FIELD_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [6:0]         cfg_data,
  // input items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [63:0] value,
  // results
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [6:0]              character,
  output logic                    is_last
);

  sdf_pkg::cfg_t       cfg;
  sdf_pkg::top_state_t state, state_next;
  sdf_pkg::emit_req_t  req;
  logic                negative;
  logic                in_fire;
  logic                conv_start;
  logic                conv_busy;
  logic                emit_busy;
  logic [63:0]         raw;
  logic [63:0]         mag;
  logic [31:0]         mag_short;
  logic [4:0]          last_step;
  logic                neg_in;
  logic [sdf_pkg::NUM_DIGITS-1:0][3:0] digits;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sdf_pkg::cfg_index_t'(cfg_index))
        sdf_pkg::CFG_FIELD_WIDTH:     cfg.field_width     <= cfg_data;
        sdf_pkg::CFG_PRECISION:       cfg.precision       <= cfg_data[5:0];
        sdf_pkg::CFG_PRECISION_GIVEN: cfg.precision_given <= cfg_data[0];
        sdf_pkg::CFG_PLUS_FLAG:       cfg.plus_flag       <= cfg_data[0];
        sdf_pkg::CFG_SPACE_FLAG:      cfg.space_flag      <= cfg_data[0];
        sdf_pkg::CFG_LEFT_JUSTIFY:    cfg.left_justify    <= cfg_data[0];
        sdf_pkg::CFG_VALUE_IS_LONG:   cfg.value_is_long   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sign and magnitude; a 32-bit value sits in the top half of the shifter
  assign raw       = value;
  assign mag_short = raw[31] ? (~raw[31:0] + 32'd1) : raw[31:0];
  always_comb begin
    if (cfg.value_is_long) begin
      neg_in    = raw[63];
      mag       = raw[63] ? (~raw + 64'd1) : raw;
      last_step = 5'(sdf_pkg::LONG_STEPS - 1);
    end else begin
      neg_in    = raw[31];
      mag       = {mag_short, 32'd0};
      last_step = 5'(sdf_pkg::SHORT_STEPS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      negative <= neg_in;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sdf_pkg::T_IDLE: if (in_fire) state_next = sdf_pkg::T_CONV;
      sdf_pkg::T_CONV: if (!conv_busy) state_next = sdf_pkg::T_EMIT;
      sdf_pkg::T_EMIT: if (!emit_busy) state_next = sdf_pkg::T_IDLE;
      default:         state_next = sdf_pkg::T_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready     = (state == sdf_pkg::T_IDLE);
    conv_start   = (state == sdf_pkg::T_IDLE) && in_valid;
    req.start    = (state == sdf_pkg::T_CONV) && !conv_busy;
    req.negative = negative;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdf_pkg::T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  sdf_bcd_unit u_bcd (
    .clk       (clk),
    .rst       (rst),
    .start     (conv_start),
    .mag       (mag),
    .last_step (last_step),
    .busy      (conv_busy),
    .digits    (digits)
  );

  sdf_emit #(
    .MAX_FIELD (MAX_FIELD)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .digits    (digits),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .is_last   (is_last)
  );

endmodule

`default_nettype wire
